[hw/rtl/tbc_pkg.sv]
// Package for the tower bin combiner: store geometry, codes and the
// transaction type passed from the front part to the back part.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tbc_pkg;
  localparam int ETA_BINS    = 64;
  localparam int PHI_BINS    = 256;
  localparam int STORE_DEPTH = ETA_BINS * PHI_BINS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int WORD_W      = 1 + 32 + 16;   // occupied, energy, time
  localparam int QUEUE_DEPTH = 4;
  localparam int GROUP_RESET = 2;

  localparam logic ACT_ACCUM = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  localparam logic CFG_ETA_GROUP = 1'b0;
  localparam logic CFG_PHI_GROUP = 1'b1;

  typedef struct packed {
    logic               action;
    logic [5:0]         ce;
    logic [7:0]         cp;
    logic signed [23:0] energy;
    logic signed [15:0] tm;
  } item_t;
endpackage
`default_nettype wire

[hw/rtl/tower_bin_combiner.sv]
// Top level of the tower bin combiner: configuration registers, front
// part, queue and back part. Uses tbc_pkg, tbc_front, tbc_queue, tbc_back.
//
// Usage:
//   Input transactions (in_*) carry an action: accumulate a fine tower into
//   its coarse bin (fine bin divided by eta_group / phi_group), or read and
//   clear a coarse bin. Each input gives exactly one result on out_*.
//   The config port (cfg_we, cfg_index, cfg_wdata) sets the group sizes;
//   write it only while the block is idle.
// Processing:
//   The front part passes a read straight on and runs an 8-step divider
//   for the coarse bin of an accumulate. The back part handles a read or
//   a first tower directly; a merge with nonzero weights also runs the
//   17-step divider of the weighted time. A 4-entry queue lets the front
//   run ahead of the back part.
// Reset:
//   rst_n is synchronous. After reset the bin store is cleared in a pass over
//   all 16384 words; in_ready stays low during it.
// Stall:
//   The result register holds while out_ready is low; the back part waits
//   and the queue then fills until in_ready drops.
`timescale 1ns / 1ps
`default_nettype none
module tower_bin_combiner (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [4:0]         cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_action,
  input  wire logic [5:0]         in_eta_bin,
  input  wire logic [7:0]         in_phi_bin,
  input  wire logic signed [23:0] in_tower_energy,
  input  wire logic signed [15:0] in_tower_time,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [5:0]              out_coarse_eta,
  output logic [7:0]              out_coarse_phi,
  output logic signed [31:0]      out_bin_energy_sum,
  output logic signed [15:0]      out_bin_time_avg,
  output logic                    out_bin_occupied
);
  import tbc_pkg::*;

  logic [4:0] eta_group_r, phi_group_r;
  logic       clr_busy, push, q_full, q_empty, pop;
  item_t      push_item, head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eta_group_r <= 5'(GROUP_RESET);
      phi_group_r <= 5'(GROUP_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ETA_GROUP: eta_group_r <= cfg_wdata;
        CFG_PHI_GROUP: phi_group_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tbc_front u_front (
    .clk(clk), .rst_n(rst_n), .clr_busy(clr_busy),
    .eta_group(eta_group_r), .phi_group(phi_group_r),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_eta_bin(in_eta_bin), .in_phi_bin(in_phi_bin),
    .in_tower_energy(in_tower_energy), .in_tower_time(in_tower_time),
    .push(push), .push_item(push_item), .q_full(q_full)
  );

  tbc_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_item(push_item),
    .full(q_full), .pop(pop), .head(head), .empty(q_empty)
  );

  tbc_back u_back (
    .clk(clk), .rst_n(rst_n), .clr_busy(clr_busy), .head(head),
    .q_empty(q_empty), .pop(pop), .out_valid(out_valid),
    .out_ready(out_ready), .out_coarse_eta(out_coarse_eta),
    .out_coarse_phi(out_coarse_phi), .out_bin_energy_sum(out_bin_energy_sum),
    .out_bin_time_avg(out_bin_time_avg), .out_bin_occupied(out_bin_occupied)
  );
endmodule
`default_nettype wire

[hw/rtl/tbc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module tbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hw/rtl/tbc_front.sv]
// Front part: accepts input transactions, maps fine bins to coarse bins
// with an iterative divider and hands them to the queue. Uses tbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tbc_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                clr_busy,
  input  wire logic [4:0]          eta_group,
  input  wire logic [4:0]          phi_group,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_action,
  input  wire logic [5:0]          in_eta_bin,
  input  wire logic [7:0]          in_phi_bin,
  input  wire logic signed [23:0]  in_tower_energy,
  input  wire logic signed [15:0]  in_tower_time,
  output logic                     push,
  output tbc_pkg::item_t           push_item,
  input  wire logic                q_full
);
  import tbc_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [2:0] cnt_r;
  item_t      item_r;
  logic [7:0] num_e_r, num_p_r;
  logic [4:0] rem_e_r, rem_p_r;
  logic [4:0] de, dp;
  logic [5:0] sh_e, sh_p;
  logic       bit_e, bit_p;
  logic       accept;

  assign de = (eta_group == 5'd0) ? 5'd1 : eta_group;
  assign dp = (phi_group == 5'd0) ? 5'd1 : phi_group;
  assign in_ready  = (state_r == F_IDLE) && !clr_busy;
  assign accept    = in_valid && in_ready;
  assign push      = (state_r == F_PUSH) && !q_full;
  assign push_item = item_r;

  // One restoring step for each coordinate
  always_comb begin
    sh_e  = {rem_e_r, num_e_r[7]};
    sh_p  = {rem_p_r, num_p_r[7]};
    bit_e = sh_e >= {1'b0, de};
    bit_p = sh_p >= {1'b0, dp};
  end

  // Sequence: accept, divide, push
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: if (accept) begin
        state_nxt = (in_action == ACT_READ) ? F_PUSH : F_DIV;
      end
      F_DIV:  if (cnt_r == 3'd7) begin
        state_nxt = F_PUSH;
      end
      F_PUSH: if (!q_full) begin
        state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath: capture, iterate, hold
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.action <= in_action;
      item_r.ce     <= in_eta_bin;
      item_r.cp     <= in_phi_bin;
      item_r.energy <= in_tower_energy;
      item_r.tm     <= in_tower_time;
      num_e_r       <= {2'b00, in_eta_bin};
      num_p_r       <= in_phi_bin;
      rem_e_r       <= 5'd0;
      rem_p_r       <= 5'd0;
      cnt_r         <= 3'd0;
    end else if (state_r == F_DIV) begin
      rem_e_r <= bit_e ? 5'(sh_e - {1'b0, de}) : sh_e[4:0];
      rem_p_r <= bit_p ? 5'(sh_p - {1'b0, dp}) : sh_p[4:0];
      num_e_r <= {num_e_r[6:0], bit_e};
      num_p_r <= {num_p_r[6:0], bit_p};
      cnt_r   <= cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        item_r.ce <= {num_e_r[4:0], bit_e};
        item_r.cp <= {num_p_r[6:0], bit_p};
      end
    end
  end
endmodule
`default_nettype wire

[hw/rtl/tbc_queue.sv]
// Short FIFO of classified transactions between front and back parts.
// Uses tbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tbc_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire tbc_pkg::item_t push_item,
  output logic                full,
  input  wire logic           pop,
  output tbc_pkg::item_t      head,
  output logic                empty
);
  import tbc_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  item_t       slots_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign full  = cnt_r == (PW+1)'(QUEUE_DEPTH);
  assign empty = cnt_r == '0;
  assign head  = slots_r[rp_r];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wp_r] <= push_item;
    end
  end
endmodule
`default_nettype wire

[hw/rtl/tbc_back.sv]
// Back part: clears the bin store after reset, then reads, merges and
// writes back one coarse bin per transaction and drives the result
// register. Uses tbc_pkg and tbc_ram.
`timescale 1ns / 1ps
`default_nettype none
module tbc_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  output logic                     clr_busy,
  input  wire tbc_pkg::item_t      head,
  input  wire logic                q_empty,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [5:0]               out_coarse_eta,
  output logic [7:0]               out_coarse_phi,
  output logic signed [31:0]       out_bin_energy_sum,
  output logic signed [15:0]       out_bin_time_avg,
  output logic                     out_bin_occupied
);
  import tbc_pkg::*;

  localparam logic [2:0] B_CLR   = 3'd0;
  localparam logic [2:0] B_IDLE  = 3'd1;
  localparam logic [2:0] B_MERGE = 3'd2;
  localparam logic [2:0] B_MUL   = 3'd3;
  localparam logic [2:0] B_ADD   = 3'd4;
  localparam logic [2:0] B_DIV   = 3'd5;
  localparam logic [2:0] B_WR    = 3'd6;
  localparam logic [2:0] B_DONE  = 3'd7;

  logic [2:0]          state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_addr_r;
  item_t               it_r;
  logic [ADDR_W-1:0]   addr;
  logic                we;
  logic [ADDR_W-1:0]   waddr;
  logic [WORD_W-1:0]   wdata, rdata;
  logic                rd_occ;
  logic signed [31:0]  rd_e;
  logic signed [15:0]  rd_t;
  logic signed [32:0]  sum_w;
  logic signed [31:0]  sum_sat;
  logic signed [31:0]  sum_r;
  logic signed [15:0]  t0_r;
  logic [31:0]         w1;
  logic [23:0]         w2;
  logic signed [48:0]  p1_r, p2_r;
  logic [32:0]         den_r;
  logic signed [49:0]  num;
  logic [49:0]         num_mag;
  logic [49:0]         n_r, ds_r, trial;
  logic                neg_r;
  logic [16:0]         q_r;
  logic [4:0]          cnt_r;
  logic signed [15:0]  t_fin;
  logic signed [31:0]  res_e_r;
  logic signed [15:0]  res_t_r;
  logic                res_occ_r;
  logic                out_free;

  assign addr     = {head.ce, head.cp};
  assign waddr    = (state_r == B_CLR) ? clr_addr_r : {it_r.ce, it_r.cp};
  assign clr_busy = state_r == B_CLR;
  assign pop      = (state_r == B_IDLE) && !q_empty;
  assign out_free = !out_valid || out_ready;
  assign {rd_occ, rd_e, rd_t} = rdata;

  tbc_ram #(.WIDTH(WORD_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(addr),
    .rdata(rdata)
  );

  // Saturating energy sum and weights
  always_comb begin
    sum_w = 33'(rd_e) + 33'(it_r.energy);
    if (sum_w > 33'sd2147483647) begin
      sum_sat = 32'sh7fffffff;
    end else if (sum_w < -33'sd2147483648) begin
      sum_sat = 32'sh80000000;
    end else begin
      sum_sat = sum_w[31:0];
    end
    w1      = sum_r[31] ? 32'(-sum_r) : sum_r;
    w2      = it_r.energy[23] ? 24'(-it_r.energy) : it_r.energy;
    num     = 50'(p1_r) + 50'(p2_r);
    num_mag = num[49] ? 50'(-num) : 50'(num);
    trial   = n_r - ds_r;
  end

  // Negate and saturate the quotient back to a signed time
  always_comb begin
    if (neg_r) begin
      t_fin = (q_r > 17'd32768) ? 16'sh8000 : 16'(-q_r);
    end else begin
      t_fin = (q_r > 17'd32767) ? 16'sd32767 : 16'(q_r);
    end
  end

  // Store writes: clearing pass, first tower, read-and-clear, merge
  always_comb begin
    we    = 1'b0;
    wdata = '0;
    case (state_r)
      B_CLR: we = 1'b1;
      B_MERGE: begin
        if (it_r.action == ACT_READ) begin
          we = rd_occ;
        end else if (!rd_occ) begin
          we    = 1'b1;
          wdata = {1'b1, 32'(it_r.energy), it_r.tm};
        end
      end
      B_WR: begin
        we    = 1'b1;
        wdata = {1'b1, sum_r, t_fin};
      end
      default: we = 1'b0;
    endcase
  end

  // Sequence of one transaction
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_CLR:   if (clr_addr_r == ADDR_W'(STORE_DEPTH - 1)) begin
        state_nxt = B_IDLE;
      end
      B_IDLE:  if (!q_empty) begin
        state_nxt = B_MERGE;
      end
      B_MERGE: begin
        if (it_r.action == ACT_ACCUM && rd_occ) begin
          state_nxt = B_MUL;
        end else begin
          state_nxt = B_DONE;
        end
      end
      B_MUL:   state_nxt = B_ADD;
      B_ADD:   state_nxt = (den_r == '0) ? B_WR : B_DIV;
      B_DIV:   if (cnt_r == 5'd0) begin
        state_nxt = B_WR;
      end
      B_WR:    state_nxt = B_DONE;
      B_DONE:  if (out_free) begin
        state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_CLR;
      clr_addr_r <= '0;
      out_valid  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_CLR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (state_r == B_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        it_r <= head;
      end
      B_MERGE: begin
        sum_r <= sum_sat;
        t0_r  <= rd_t;
        if (it_r.action == ACT_READ) begin
          res_occ_r <= rd_occ;
          res_e_r   <= rd_occ ? rd_e : 32'sd0;
          res_t_r   <= rd_occ ? rd_t : 16'sd0;
        end else begin
          res_occ_r <= 1'b1;
          res_e_r   <= 32'(it_r.energy);
          res_t_r   <= it_r.tm;
        end
      end
      B_MUL: begin
        p1_r  <= $signed({1'b0, w1}) * t0_r;
        p2_r  <= 49'($signed({1'b0, w2}) * it_r.tm);
        den_r <= 33'(w1) + 33'(w2);
      end
      B_ADD: begin
        n_r   <= num_mag + 50'(den_r >> 1);
        ds_r  <= {1'b0, den_r, 16'b0};
        neg_r <= num[49];
        q_r   <= '0;
        cnt_r <= 5'd16;
      end
      B_DIV: begin
        if (!trial[49]) begin
          n_r <= trial;
        end
        q_r   <= {q_r[15:0], !trial[49]};
        ds_r  <= ds_r >> 1;
        cnt_r <= cnt_r - 5'd1;
      end
      B_WR: begin
        res_e_r <= sum_r;
        res_t_r <= (den_r == '0) ? 16'sd0 : t_fin;
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (state_r == B_DONE && out_free) begin
      out_coarse_eta     <= it_r.ce;
      out_coarse_phi     <= it_r.cp;
      out_bin_energy_sum <= res_e_r;
      out_bin_time_avg   <= res_t_r;
      out_bin_occupied   <= res_occ_r;
    end
  end
endmodule
`default_nettype wire

[hw/rtl/tbc_checker.sv]
// Port-level checks for the tower bin combiner, bound to the top level.
// Depends on tower_bin_combiner ports only.
`timescale 1ns / 1ps
`default_nettype none
module tbc_port_checks (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [5:0]         out_coarse_eta,
  input wire logic [7:0]         out_coarse_phi,
  input wire logic signed [31:0] out_bin_energy_sum,
  input wire logic signed [15:0] out_bin_time_avg,
  input wire logic               out_bin_occupied
);
  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bin_energy_sum)
      && $stable(out_bin_time_avg) && $stable(out_coarse_eta)
      && $stable(out_coarse_phi))
    else $error("result changed while stalled");

  // Empty bins report zero
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bin_occupied |-> out_bin_energy_sum == 0
      && out_bin_time_avg == 0)
    else $error("empty bin with nonzero payload");

  // No input during the clearing pass right after reset
  a_clr_block: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !in_ready)
    else $error("input taken during clearing pass");

  // Reset drops the result
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind tower_bin_combiner tbc_port_checks u_tbc_port_checks (.*);
`default_nettype wire
